/* rtl/kar_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kar_pkg: shared definitions for the key auto-repeat table
// Slot count, field widths, command and register codes, and the control and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kar_pkg;

  localparam int SLOTS       = 16;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam int KEY_W   = 8;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFGIX_W = 4;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_DOWN  = 2'd1,
    CMD_UP    = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  localparam logic [CFGIX_W-1:0] CFG_FIRST_DELAY  = CFGIX_W'(0);
  localparam logic [CFGIX_W-1:0] CFG_REPEAT_DELAY = CFGIX_W'(1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the accepted item and restart the scan
    logic step;   // process the slot under the scan index
    logic flush;  // move the held result to the output as the last one
    logic clear;  // free every slot at once
  } kar_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stall;      // the current slot fired but the output cannot take the held item
    logic last_slot;  // the scan index points at the final slot
    logic hold_valid; // a result is held back waiting to learn whether it is the last
    logic out_free;   // the output register can be loaded this cycle
  } kar_stat_t;

endpackage

/* rtl/key_auto_repeat_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_auto_repeat_table: typematic repeat generator for held keys
// Tracks up to SLOTS held keys and emits a repeat item for each key whose
// repeat delay has run out on a tick.
// ----------------------------------------------------------------------------
// A tick, key-down or key-up item is accepted in the idle state; the scan then
// visits the slot table one entry per cycle unless a stall holds it, and the
// flush state then releases the final result, if any, once the output register
// is free. A clear item is taken without a scan, and the block is ready again
// right away, since it never leaves the idle state. Each
// tick gives one repeat item for every held key that fires, in slot order,
// and the final one of the tick carries last_o. Because the block must know
// whether a result is the last one before releasing it, one result is always
// held back during the scan; a slow consumer on the output side stalls the
// scan only when a second result is ready and the output register is full.
// The delay registers are written through the configuration channel, which
// is always ready; index 0 is first_delay and index 1 is repeat_delay, and
// writes to any other index are dropped. Write them only while the block is
// idle.
// ----------------------------------------------------------------------------
module key_auto_repeat_table import kar_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [KEY_W-1:0]   key_code_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [KEY_W-1:0]   repeat_key_o,
  output logic [CNT_W-1:0]   repeat_number_o,
  output logic               last_o,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFGIX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i
);

  kar_ctrl_t ctrl;
  kar_stat_t stat;

  // The delay registers accept a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // The controller owns the input handshake and sequences the slot scan.
  kar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // The datapath holds the slots, the delays and the output register.
  kar_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cmd_i           (cmd_i),
    .key_code_i      (key_code_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .repeat_key_o    (repeat_key_o),
    .repeat_number_o (repeat_number_o),
    .last_o          (last_o)
  );

endmodule

/* rtl/kar_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kar_ctrl: sequencer for the key auto-repeat table
// Accepts an item; for all but a clear it steps the datapath over every slot
// and then flushes any held result with its last flag set.
// ----------------------------------------------------------------------------
module kar_ctrl import kar_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [1:0] cmd_i,
  input  kar_stat_t stat_i,
  output kar_ctrl_t ctrl_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    ctrl_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_CLEAR) begin
            ctrl_o.clear = 1'b1;
          end else begin
            ctrl_o.load = 1'b1;
            state_d     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ctrl_o.step = 1'b1;
        if (!stat_i.stall && stat_i.last_slot) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat_i.hold_valid) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          ctrl_o.flush = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/kar_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kar_datapath: slot table, delay registers and result path
// Holds the repeater slots, processes one slot per step, and keeps one
// result back so that the last result of a tick can be flagged.
// ----------------------------------------------------------------------------
module kar_datapath import kar_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kar_ctrl_t          ctrl_i,
  output kar_stat_t          stat_o,
  input  logic [1:0]         cmd_i,
  input  logic [KEY_W-1:0]   key_code_i,
  input  logic               cfg_valid_i,
  input  logic [CFGIX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [KEY_W-1:0]   repeat_key_o,
  output logic [CNT_W-1:0]   repeat_number_o,
  output logic               last_o
);

  logic [KEY_W-1:0]  slot_key_q     [SLOTS];
  logic [CNT_W-1:0]  slot_elapsed_q [SLOTS];
  logic [CNT_W-1:0]  slot_count_q   [SLOTS];

  logic [CFG_W-1:0]  first_q, repeat_q;
  logic [1:0]        cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic              claimed_q;
  logic [IDX_W-1:0]  idx_q;
  logic [NRES_W-1:0] nres_q;

  logic              hold_valid_q;
  logic [KEY_W-1:0]  hold_key_q;
  logic [CNT_W-1:0]  hold_num_q;

  logic              out_valid_q;
  logic [KEY_W-1:0]  out_key_q;
  logic [CNT_W-1:0]  out_num_q;
  logic              out_last_q;

  logic [KEY_W-1:0]  cur_key;
  logic [CNT_W-1:0]  cur_el, cur_cnt, el_inc, cnt_inc, thr_raw, thr;
  logic              used, fire, out_free, stall, do_step;
  logic              is_tick, do_claim, do_free, push_out;

  assign cur_key = slot_key_q[idx_q];
  assign cur_el  = slot_elapsed_q[idx_q];
  assign cur_cnt = slot_count_q[idx_q];
  assign used    = (cur_key != '0);

  // Elapsed and repeat counts saturate at their full range.
  assign el_inc  = (cur_el == '1) ? cur_el : cur_el + 1'b1;
  assign cnt_inc = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;

  // A delay register holding zero behaves as a delay of one tick.
  assign thr_raw = (cur_cnt == '0) ? first_q : repeat_q;
  assign thr     = (thr_raw == '0) ? CNT_W'(1) : thr_raw;

  assign is_tick  = (cmd_q == CMD_TICK);
  assign fire     = is_tick && used && (el_inc >= thr) && (nres_q < NRES_W'(MAX_RESULTS));
  assign out_free = !out_valid_q || out_ready_i;
  assign stall    = fire && hold_valid_q && !out_free;
  assign do_step  = ctrl_i.step && !stall;
  assign do_claim = do_step && (cmd_q == CMD_DOWN) && !claimed_q && !used;
  assign do_free  = do_step && (cmd_q == CMD_UP) && (key_q != '0) && (cur_key == key_q);
  assign push_out = do_step && fire && hold_valid_q;

  assign stat_o.stall      = stall;
  assign stat_o.last_slot  = (idx_q == IDX_W'(SLOTS - 1));
  assign stat_o.hold_valid = hold_valid_q;
  assign stat_o.out_free   = out_free;

  assign out_valid_o     = out_valid_q;
  assign repeat_key_o    = out_key_q;
  assign repeat_number_o = out_num_q;
  assign last_o          = out_last_q;

  // Slot keys mark occupancy, so they are cleared by reset and by a clear item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_key_q[i] <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_key_q[i] <= '0;
      end
    end else if (do_claim) begin
      slot_key_q[idx_q] <= key_q;
    end else if (do_free) begin
      slot_key_q[idx_q] <= '0;
    end
  end

  // Counts only matter while a slot is held, and claiming a slot zeroes them.
  always_ff @(posedge clk_i) begin
    if (do_claim) begin
      slot_elapsed_q[idx_q] <= '0;
      slot_count_q[idx_q]   <= '0;
    end else if (do_step && is_tick && used) begin
      slot_elapsed_q[idx_q] <= fire ? el_inc - thr : el_inc;
      if (fire) begin
        slot_count_q[idx_q] <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= CFG_W'(15);
      repeat_q <= CFG_W'(3);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FIRST_DELAY) begin
        first_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_REPEAT_DELAY) begin
        repeat_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= CMD_TICK;
      key_q     <= '0;
      claimed_q <= 1'b0;
      idx_q     <= '0;
      nres_q    <= '0;
    end else if (ctrl_i.load) begin
      cmd_q     <= cmd_i;
      key_q     <= key_code_i;
      claimed_q <= (key_code_i == '0);
      idx_q     <= '0;
      nres_q    <= '0;
    end else if (do_step) begin
      idx_q <= stat_o.last_slot ? '0 : idx_q + 1'b1;
      if (do_claim) begin
        claimed_q <= 1'b1;
      end
      if (fire) begin
        nres_q <= nres_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (do_step && fire) begin
      hold_valid_q <= 1'b1;
    end else if (ctrl_i.flush) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step && fire) begin
      hold_key_q <= cur_key;
      hold_num_q <= cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_out || ctrl_i.flush) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_out || ctrl_i.flush) begin
      out_key_q  <= hold_key_q;
      out_num_q  <= hold_num_q;
      out_last_q <= ctrl_i.flush;
    end
  end

endmodule
